[rtl/core/sgr_pkg.sv]
// Package for the scaled glyph rectangle generator.
// Holds the item types, the control structs, register indexes and the font ROM.
// Used by every module of the block; depends on nothing.
package sgr_pkg;

  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;
  localparam int GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;
  localparam int CELL_COLS  = 6;

  localparam logic [7:0] CODE_LIMIT = 8'd128;
  localparam logic [2:0] LAST_ROW   = 3'(GLYPH_ROWS - 1);
  localparam logic [2:0] LAST_COL   = 3'(GLYPH_COLS - 1);
  localparam logic [4:0] SCALE_MIN  = 5'd1;
  localparam logic [4:0] SCALE_MAX  = 5'd16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_FG_COLOR    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BG_COLOR    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_SCALE = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANSPARENT = 2'd3;

  localparam logic [15:0] FG_COLOR_RESET = 16'hFFFF;
  localparam logic [15:0] BG_COLOR_RESET = 16'h0000;

  typedef struct packed {
    logic [7:0]         char_code;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic               new_text;
  } char_item_t;

  typedef struct packed {
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [4:0]         rect_w;
    logic [6:0]         rect_h;
    logic [15:0]        rect_color;
    logic               last_rect;
  } rect_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SPACER
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit_pixel;
    logic emit_spacer;
  } dp_cmd_t;

  typedef struct packed {
    logic code_valid;
    logic transparent;
    logic pixel_set;
    logic last_pos;
    logic out_free;
  } dp_status_t;

  // Glyph bitmap, column-major: bit col*7+row is the pixel at that column and row.
  function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [6:0] code);
    logic [39:0]           cols;
    logic [GLYPH_BITS-1:0] flat;
    unique case (code)
      7'd46:   cols = 40'h00_00_60_60_00;
      7'd58:   cols = 40'h00_00_36_36_00;
      7'd48:   cols = 40'h3E_51_49_45_3E;
      7'd49:   cols = 40'h00_40_7F_42_00;
      7'd50:   cols = 40'h46_49_51_61_42;
      7'd51:   cols = 40'h31_4B_45_41_21;
      7'd52:   cols = 40'h10_7F_12_14_18;
      7'd53:   cols = 40'h39_45_45_45_27;
      7'd54:   cols = 40'h30_49_49_49_3E;
      7'd55:   cols = 40'h03_05_09_71_01;
      7'd56:   cols = 40'h36_49_49_49_36;
      7'd57:   cols = 40'h1E_29_49_49_06;
      7'd65:   cols = 40'h7E_09_09_09_7E;
      7'd66:   cols = 40'h36_49_49_49_7F;
      7'd67:   cols = 40'h22_41_41_41_3E;
      7'd68:   cols = 40'h1C_22_41_41_7F;
      7'd69:   cols = 40'h41_49_49_49_7F;
      7'd71:   cols = 40'h3A_49_49_41_3E;
      7'd72:   cols = 40'h7F_08_08_08_7F;
      7'd73:   cols = 40'h00_41_7F_41_00;
      7'd76:   cols = 40'h40_40_40_40_7F;
      7'd78:   cols = 40'h7F_08_04_02_7F;
      7'd79:   cols = 40'h3E_41_41_41_3E;
      7'd80:   cols = 40'h06_09_09_09_7F;
      7'd82:   cols = 40'h46_29_19_09_7F;
      7'd83:   cols = 40'h31_49_49_49_46;
      7'd84:   cols = 40'h01_01_7F_01_01;
      7'd85:   cols = 40'h3F_40_40_40_3F;
      7'd86:   cols = 40'h1F_20_40_20_1F;
      7'd88:   cols = 40'h63_14_08_14_63;
      7'd89:   cols = 40'h03_04_78_04_03;
      default: cols = 40'h0;
    endcase
    for (int c = 0; c < GLYPH_COLS; c++) begin
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        flat[c*GLYPH_ROWS + r] = cols[c*8 + r];
      end
    end
    return flat;
  endfunction

endpackage

[rtl/core/sgr_ctrl.sv]
// Controller state machine for the scaled glyph rectangle generator.
// Sequences the pixel walk and spacer column through dp_cmd_t commands.
// Depends on sgr_pkg.
module sgr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_stall,
  input  sgr_pkg::dp_status_t status,
  output sgr_pkg::dp_cmd_t    cmd
);

  sgr_pkg::ctrl_state_t state, state_next;
  logic                 need_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sgr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign need_emit = status.pixel_set || !status.transparent;

  always_comb begin
    state_next = state;
    cmd        = '0;
    char_stall = 1'b1;
    unique case (state)
      sgr_pkg::ST_IDLE: begin
        char_stall = 1'b0;
        if (char_valid) begin
          cmd.load   = 1'b1;
          state_next = sgr_pkg::ST_WALK;
        end
      end
      sgr_pkg::ST_WALK: begin
        if (!status.code_valid) begin
          state_next = sgr_pkg::ST_IDLE;
        end else if (!need_emit || status.out_free) begin
          cmd.step       = 1'b1;
          cmd.emit_pixel = need_emit;
          if (status.last_pos) begin
            state_next = status.transparent ? sgr_pkg::ST_IDLE : sgr_pkg::ST_SPACER;
          end
        end
      end
      sgr_pkg::ST_SPACER: begin
        if (status.out_free) begin
          cmd.emit_spacer = 1'b1;
          state_next      = sgr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sgr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/sgr_datapath.sv]
// Datapath for the scaled glyph rectangle generator.
// Holds the configuration registers, pen, glyph shift register, walk position
// and the result output register. Depends on sgr_pkg.
module sgr_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [sgr_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [sgr_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  sgr_pkg::char_item_t                   char_item,
  output logic                                  rect_valid,
  input  logic                                  rect_stall,
  output sgr_pkg::rect_item_t                   rect_item,
  input  sgr_pkg::dp_cmd_t                      cmd,
  output sgr_pkg::dp_status_t                   status
);

  logic [15:0] fg_color;
  logic [15:0] bg_color;
  logic [4:0]  pixel_scale;
  logic        transparent_mode;
  logic [15:0] pen_x;

  logic [sgr_pkg::GLYPH_BITS-1:0] glyph_sr;
  logic                           code_ok;
  logic [4:0]                     scale;
  logic [15:0]                    x_cur;
  logic [15:0]                    y0;
  logic [15:0]                    y_cur;
  logic [2:0]                     row;
  logic [2:0]                     col;

  logic [4:0]  scale_eff;
  logic [15:0] x0;
  logic [6:0]  cell_w;
  logic [6:0]  spacer_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color         <= sgr_pkg::FG_COLOR_RESET;
      bg_color         <= sgr_pkg::BG_COLOR_RESET;
      pixel_scale      <= sgr_pkg::SCALE_MIN;
      transparent_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgr_pkg::REG_FG_COLOR:    fg_color         <= cfg_data;
        sgr_pkg::REG_BG_COLOR:    bg_color         <= cfg_data;
        sgr_pkg::REG_PIXEL_SCALE: pixel_scale      <= cfg_data[4:0];
        sgr_pkg::REG_TRANSPARENT: transparent_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pixel_scale == 5'd0) begin
      scale_eff = sgr_pkg::SCALE_MIN;
    end else if (pixel_scale > sgr_pkg::SCALE_MAX) begin
      scale_eff = sgr_pkg::SCALE_MAX;
    end else begin
      scale_eff = pixel_scale;
    end
  end

  assign x0       = char_item.new_text ? char_item.start_x : pen_x;
  assign cell_w   = 7'(scale_eff) * 7'(sgr_pkg::CELL_COLS);
  assign spacer_h = 7'(scale) * 7'(sgr_pkg::GLYPH_ROWS);

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x <= 16'd0;
    end else if (cmd.load) begin
      pen_x <= x0 + {9'd0, cell_w};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      glyph_sr <= sgr_pkg::glyph_bits(char_item.char_code[6:0]);
      code_ok  <= char_item.char_code < sgr_pkg::CODE_LIMIT;
      scale    <= scale_eff;
      x_cur    <= x0;
      y0       <= char_item.start_y;
      y_cur    <= char_item.start_y;
      row      <= 3'd0;
      col      <= 3'd0;
    end else if (cmd.step) begin
      glyph_sr <= glyph_sr >> 1;
      if (row == sgr_pkg::LAST_ROW) begin
        row   <= 3'd0;
        col   <= col + 3'd1;
        x_cur <= x_cur + {11'd0, scale};
        y_cur <= y0;
      end else begin
        row   <= row + 3'd1;
        y_cur <= y_cur + {11'd0, scale};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_valid <= 1'b0;
    end else if (cmd.emit_pixel || cmd.emit_spacer) begin
      rect_valid <= 1'b1;
    end else if (!rect_stall) begin
      rect_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pixel) begin
      rect_item.rect_x     <= x_cur;
      rect_item.rect_y     <= y_cur;
      rect_item.rect_w     <= scale;
      rect_item.rect_h     <= {2'b00, scale};
      rect_item.rect_color <= glyph_sr[0] ? fg_color : bg_color;
      rect_item.last_rect  <= transparent_mode && !(|glyph_sr[sgr_pkg::GLYPH_BITS-1:1]);
    end else if (cmd.emit_spacer) begin
      rect_item.rect_x     <= x_cur;
      rect_item.rect_y     <= y0;
      rect_item.rect_w     <= scale;
      rect_item.rect_h     <= spacer_h;
      rect_item.rect_color <= bg_color;
      rect_item.last_rect  <= 1'b1;
    end
  end

  assign status.code_valid  = code_ok;
  assign status.transparent = transparent_mode;
  assign status.pixel_set   = glyph_sr[0];
  assign status.last_pos    = (col == sgr_pkg::LAST_COL) && (row == sgr_pkg::LAST_ROW);
  assign status.out_free    = !rect_valid || !rect_stall;

endmodule

[rtl/core/scaled_glyph_rect_generator.sv]
// Top level of the scaled glyph rectangle generator.
// Joins the controller (sgr_ctrl) and the datapath (sgr_datapath); depends on sgr_pkg.
//
// Takes one character item and issues fill-rectangle items from a built-in 5x7
// font, each glyph pixel a square of side pixel_scale (0 acts as 1, above 16 as 16),
// walked column by column, rows top to bottom. In opaque mode a character gives
// its 35 pixels and a spacer column; in transparent mode clear pixels are still
// walked but issue nothing. A code of 128 or more issues nothing. The walk visits
// one glyph position per cycle while the output is free; output stalls hold it,
// and a new character is taken only once the block is idle again.
// The pen advances by six pixel widths per character and new_text reloads it.
module scaled_glyph_rect_generator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sgr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sgr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            char_valid,
  output logic                            char_stall,
  input  sgr_pkg::char_item_t             char_item,
  output logic                            rect_valid,
  input  logic                            rect_stall,
  output sgr_pkg::rect_item_t             rect_item
);

  sgr_pkg::dp_cmd_t    cmd;
  sgr_pkg::dp_status_t status;

  sgr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .status     (status),
    .cmd        (cmd)
  );

  sgr_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .char_item  (char_item),
    .rect_valid (rect_valid),
    .rect_stall (rect_stall),
    .rect_item  (rect_item),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

[tb/sv/glyph_rect_checker.sv]
// Checker for the scaled glyph rectangle generator: mirrors the registers,
// predicts the rectangles of every accepted character and compares the results.
// Depends on sgr_pkg for the item types, register indexes and glyph sizes.
`timescale 1ns / 1ps

module glyph_rect_checker
  import sgr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   char_valid,
  input  logic                   char_stall,
  input  char_item_t             char_item,
  input  logic                   rect_valid,
  input  logic                   rect_stall,
  input  rect_item_t             rect_item,
  output int                     mismatches,
  output int                     pending
);

  logic [15:0] fg_color_q;
  logic [15:0] bg_color_q;
  logic [4:0]  scale_q;
  logic        transparent_q;
  logic [15:0] pen_x_q;
  rect_item_t  expected_rects[$];
  int          rects_seen;

  function automatic logic [7:0] glyph_column(input logic [7:0] code, input int col);
    logic [39:0] cols;
    case (code)
      ".":     cols = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
      ":":     cols = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
      "0":     cols = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
      "1":     cols = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
      "2":     cols = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
      "3":     cols = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
      "4":     cols = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
      "5":     cols = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
      "6":     cols = {8'h3E, 8'h49, 8'h49, 8'h49, 8'h30};
      "7":     cols = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
      "8":     cols = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      "9":     cols = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
      "A":     cols = {8'h7E, 8'h09, 8'h09, 8'h09, 8'h7E};
      "B":     cols = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
      "C":     cols = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
      "D":     cols = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
      "E":     cols = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
      "G":     cols = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h3A};
      "H":     cols = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      "I":     cols = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      "L":     cols = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
      "N":     cols = {8'h7F, 8'h02, 8'h04, 8'h08, 8'h7F};
      "O":     cols = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      "P":     cols = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
      "R":     cols = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
      "S":     cols = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
      "T":     cols = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      "U":     cols = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
      "V":     cols = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
      "X":     cols = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      "Y":     cols = {8'h03, 8'h04, 8'h78, 8'h04, 8'h03};
      default: cols = '0;
    endcase
    return cols[8*(GLYPH_COLS-1-col) +: 8];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: rect %0d: %s", $time, rects_seen, msg);
    mismatches++;
  endtask

  // Rectangles are held back by one so the final one of a character can be marked.
  task automatic draw_char(input char_item_t c);
    logic [4:0]  s;
    logic [15:0] x0;
    logic [7:0]  bits;
    rect_item_t  r;
    rect_item_t  held;
    bit          have_held;
    s = (scale_q == 5'd0) ? SCALE_MIN : (scale_q > SCALE_MAX) ? SCALE_MAX : scale_q;
    have_held = 1'b0;
    held = '0;
    if (c.new_text) pen_x_q = c.start_x;
    x0 = pen_x_q;
    if (c.char_code < CODE_LIMIT) begin
      for (int col = 0; col < GLYPH_COLS; col++) begin
        bits = glyph_column(c.char_code, col);
        for (int row = 0; row < GLYPH_ROWS; row++) begin
          if (bits[row] || !transparent_q) begin
            r.rect_x     = x0 + 16'(col * s);
            r.rect_y     = c.start_y + 16'(row * s);
            r.rect_w     = s;
            r.rect_h     = 7'(s);
            r.rect_color = bits[row] ? fg_color_q : bg_color_q;
            r.last_rect  = 1'b0;
            if (have_held) expected_rects.push_back(held);
            held = r;
            have_held = 1'b1;
          end
        end
      end
      if (!transparent_q) begin
        r.rect_x     = x0 + 16'(GLYPH_COLS * s);
        r.rect_y     = c.start_y;
        r.rect_w     = s;
        r.rect_h     = 7'(GLYPH_ROWS * s);
        r.rect_color = bg_color_q;
        r.last_rect  = 1'b0;
        if (have_held) expected_rects.push_back(held);
        held = r;
        have_held = 1'b1;
      end
      if (have_held) begin
        held.last_rect = 1'b1;
        expected_rects.push_back(held);
      end
    end
    pen_x_q = x0 + 16'(CELL_COLS * s);
  endtask

  task automatic check_rect(input rect_item_t got);
    rect_item_t want;
    if (expected_rects.size() == 0) begin
      report_mismatch($sformatf("unexpected rect x=%h y=%h", got.rect_x, got.rect_y));
    end else begin
      want = expected_rects.pop_front();
      if (got.rect_x !== want.rect_x)
        report_mismatch($sformatf("rect_x %h, expected %h", got.rect_x, want.rect_x));
      if (got.rect_y !== want.rect_y)
        report_mismatch($sformatf("rect_y %h, expected %h", got.rect_y, want.rect_y));
      if (got.rect_w !== want.rect_w)
        report_mismatch($sformatf("rect_w %0d, expected %0d", got.rect_w, want.rect_w));
      if (got.rect_h !== want.rect_h)
        report_mismatch($sformatf("rect_h %0d, expected %0d", got.rect_h, want.rect_h));
      if (got.rect_color !== want.rect_color)
        report_mismatch($sformatf("rect_color %h, expected %h", got.rect_color,
                                  want.rect_color));
      if (got.last_rect !== want.last_rect)
        report_mismatch($sformatf("last_rect %b, expected %b", got.last_rect,
                                  want.last_rect));
    end
    rects_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fg_color_q    = FG_COLOR_RESET;
      bg_color_q    = BG_COLOR_RESET;
      scale_q       = SCALE_MIN;
      transparent_q = 1'b0;
      pen_x_q       = '0;
      rects_seen    = 0;
      mismatches    = 0;
      expected_rects.delete();
    end else begin
      if (rect_valid && !rect_stall) check_rect(rect_item);
      if (cfg_we) begin
        case (cfg_index)
          REG_FG_COLOR:    fg_color_q    = cfg_data;
          REG_BG_COLOR:    bg_color_q    = cfg_data;
          REG_PIXEL_SCALE: scale_q       = cfg_data[4:0];
          REG_TRANSPARENT: transparent_q = cfg_data[0];
          default: ;
        endcase
      end
      if (char_valid && !char_stall) draw_char(char_item);
    end
    pending = expected_rects.size();
  end

endmodule

[tb/sv/tb_scaled_glyph_rect_generator.sv]
// Top of the testbench for the scaled glyph rectangle generator: drives
// characters and register writes, stalls the rectangle side and gives the verdict.
// Depends on sgr_pkg, the block itself and glyph_rect_checker.
`timescale 1ns / 1ps

module tb_scaled_glyph_rect_generator;
  import sgr_pkg::*;

  localparam int DRAIN_CYCLES     = 40;
  localparam int LONG_HOLD        = 300;
  localparam int IDLE_LIMIT       = 2000;
  localparam int RANDOM_PER_PHASE = 50;

  // Codes that have a glyph in the font, plus a blank one.
  localparam logic [8*32-1:0] DRAWN_CODES = "0123456789ABCDEGHILNOPRSTUVXY.: ";

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   cfg_we     = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   char_valid = 1'b0;
  char_item_t             char_item  = '0;
  logic                   rect_stall = 1'b0;
  logic                   char_stall;
  logic                   rect_valid;
  rect_item_t             rect_item;
  int                     mismatches;
  int                     pending;
  int                     hold_requests = 0;

  scaled_glyph_rect_generator i_dut (.*);

  glyph_rect_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic char_item_t mk_char(input logic [7:0] code, input logic [15:0] sx,
                                         input logic [15:0] sy, input logic nt);
    char_item_t c;
    c.char_code = code;
    c.start_x   = sx;
    c.start_y   = sy;
    c.new_text  = nt;
    return c;
  endfunction

  function automatic char_item_t random_char();
    char_item_t c;
    int         pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) c.char_code = DRAWN_CODES[8*$urandom_range(0, 31) +: 8];
    else if (pick < 17) c.char_code = 8'($urandom_range(0, 127));
    else c.char_code = 8'($urandom_range(128, 255));
    c.start_x  = 16'($urandom);
    c.start_y  = 16'($urandom);
    c.new_text = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 5) == 0) c.start_x = 16'h7FFF - 16'($urandom_range(0, 120));
    if ($urandom_range(0, 5) == 0) c.start_y = 16'h7FFF - 16'($urandom_range(0, 120));
    if ($urandom_range(0, 7) == 0) c.start_y = 16'hFFFF - 16'($urandom_range(0, 120));
    return c;
  endfunction

  task automatic send_char(input char_item_t c);
    char_valid <= 1'b1;
    char_item  <= c;
    @(posedge clk);
    while (char_stall) @(posedge clk);
  endtask

  task automatic idle_sender(input int cycles);
    char_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Blank glyphs in transparent mode leave the block busy with nothing expected,
  // hence the extra cycles after the last result.
  task automatic wait_drained(input int extra);
    char_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_style(input logic [15:0] fg, input logic [15:0] bg,
                           input logic [15:0] scale, input logic [15:0] transp);
    write_reg(REG_FG_COLOR, fg);
    write_reg(REG_BG_COLOR, bg);
    write_reg(REG_PIXEL_SCALE, scale);
    write_reg(REG_TRANSPARENT, transp);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int count);
    int burst;
    burst = $urandom_range(1, 8);
    repeat (count) begin
      send_char(random_char());
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 8);
        if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 45));
      end
    end
  endtask

  initial begin
    rx_mode_t rx_mode;
    int       mode_left;
    int       hold_left;
    int       holds_started;
    bit       stall_now;
    rx_mode = RX_FREE;
    mode_left = 0;
    hold_left = 0;
    holds_started = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_requests != holds_started) begin
        holds_started++;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 150);
      end
      mode_left--;
      case (rx_mode)
        RX_FREE:  stall_now = 1'b0;
        RX_LIGHT: stall_now = ($urandom_range(0, 3) == 0);
        RX_HEAVY: stall_now = ($urandom_range(0, 3) != 0);
        default:  stall_now = !rect_stall;
      endcase
      rect_stall <= (hold_left > 0) || stall_now;
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    wait (!rst);
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((char_valid && !char_stall) || (rect_valid && !rect_stall)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset style: opaque, scale 1, white on black.
    send_char(mk_char("0", 16'h0000, 16'h0000, 1'b1));
    send_char(mk_char("8", 16'h1111, 16'h0010, 1'b0));
    send_char(mk_char(8'h00, 16'h0000, 16'h0020, 1'b0));
    send_char(mk_char(" ", 16'h0000, 16'h0020, 1'b0));
    send_char(mk_char(8'h7F, 16'h0000, 16'h0030, 1'b0));
    send_char(mk_char(8'h80, 16'h1234, 16'h0040, 1'b1));
    send_char(mk_char(8'hFF, 16'h0000, 16'hFFFF, 1'b0));
    send_char(mk_char("X", 16'h7FFF, 16'h7FFF, 1'b1));
    send_char(mk_char("T", 16'h8000, 16'h8000, 1'b1));
    send_char(mk_char("Y", 16'hFFFE, 16'hFFFD, 1'b1));
    send_char(mk_char(":", 16'h0000, 16'h7FFA, 1'b0));
    send_char(mk_char("M", 16'hABCD, 16'h5432, 1'b1));
    run_random(RANDOM_PER_PHASE);
    wait_drained(DRAIN_CYCLES);

    set_style(16'h0000, 16'hFFFF, 16'd16, 16'h0000);
    send_char(mk_char("8", 16'h7FE0, 16'h7FC0, 1'b1));
    run_random(RANDOM_PER_PHASE);
    wait_drained(DRAIN_CYCLES);

    set_style(16'($urandom), 16'($urandom), {11'($urandom), 5'd0}, {15'($urandom), 1'b1});
    run_random(RANDOM_PER_PHASE);
    wait_drained(DRAIN_CYCLES);

    // Scale above the range acts as the maximum; transparent drops clear pixels.
    set_style(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001);
    send_char(mk_char(" ", 16'h0100, 16'h0100, 1'b1));
    send_char(mk_char("1", 16'h0000, 16'h0000, 1'b0));
    send_char(mk_char(8'hC8, 16'h7FF0, 16'h7FF0, 1'b1));
    send_char(mk_char("8", 16'h0000, 16'h7FF0, 1'b0));
    send_char(mk_char(8'h00, 16'h0000, 16'h0000, 1'b0));
    run_random(RANDOM_PER_PHASE - 5);
    wait_drained(DRAIN_CYCLES);

    set_style(16'($urandom), 16'($urandom), 16'd2, 16'h0000);
    hold_requests <= hold_requests + 1;
    run_random(RANDOM_PER_PHASE);
    wait_drained(DRAIN_CYCLES);

    set_style(16'($urandom), 16'($urandom), 16'd17, 16'hFFFE);
    run_random(RANDOM_PER_PHASE / 2);
    wait_drained(0);
    run_random(RANDOM_PER_PHASE / 2);
    wait_drained(DRAIN_CYCLES);

    set_style(16'($urandom), 16'($urandom), 16'($urandom_range(1, 16)),
              16'($urandom_range(0, 1)));
    run_random(RANDOM_PER_PHASE);
    wait_drained(DRAIN_CYCLES);

    set_style(16'($urandom), 16'($urandom), 16'd1, 16'h0001);
    run_random(RANDOM_PER_PHASE);
    wait_drained(DRAIN_CYCLES);

    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/sgr_pkg.sv
rtl/core/sgr_ctrl.sv
rtl/core/sgr_datapath.sv
rtl/core/scaled_glyph_rect_generator.sv
tb/sv/glyph_rect_checker.sv
tb/sv/tb_scaled_glyph_rect_generator.sv
